>>> design/trre_pkg.sv
// Shared types, constants and the opcode operand table of the track row encoder.
// Has no dependencies; every other file of the block but trre_row_mem refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package trre_pkg;

  localparam int unsigned ROW_PAYLOAD_MAX_DEF = 30;
  localparam int unsigned REPEAT_MAX_DEF      = 8;
  localparam int unsigned REP_W               = 4;
  localparam int unsigned APB_ADDR_W          = 3;

  localparam logic [7:0] OPCODE_LIMIT  = 8'd62;
  localparam logic [7:0] PATTERN_BASE  = 8'd3;
  localparam logic [7:0] VOLUME_OPCODE = 8'd30;
  localparam logic [4:0] LENGTH_MASK   = 5'h1f;

  typedef enum logic [2:0] {
    KIND_BYTE      = 3'd0,
    KIND_EFFECT    = 3'd1,
    KIND_PATTERN   = 3'd2,
    KIND_VOLUME    = 3'd3,
    KIND_ROW_END   = 3'd4,
    KIND_TRACK_END = 3'd5,
    KIND_START     = 3'd6
  } kind_e;

  // Up to three bytes a command appends to the current row, first byte in slot 0.
  typedef struct packed {
    logic [1:0]      count;
    logic [2:0][7:0] bytes;
  } append_t;

  // Opcodes whose operand is a big-endian 16-bit word.
  function automatic logic two_operands(input logic [7:0] op);
    logic res;
    res = op inside {8'd30, 8'd54, 8'd56, 8'd57, 8'd61};
    return res;
  endfunction

endpackage

`default_nettype wire

>>> design/trre_row_mem.sv
// Row store of the track row encoder: two banks (current and previous row) in one
// synchronous RAM, one write and one registered read per cycle. No package use.
`timescale 1ns / 1ps
`default_nettype none

module trre_row_mem #(
  parameter int unsigned AddrW = 6
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [7:0]       wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [7:0]       rdata_o
);

  localparam int unsigned Depth = 2 ** AddrW;

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // The read register holds its value until the next read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/trre_cmd_decode.sv
// Command decoder: turns one input command into the list of bytes it appends.
// Depends on trre_pkg for the command kinds, the append list type and the operand table.
`timescale 1ns / 1ps
`default_nettype none

module trre_cmd_decode (
  input  wire trre_pkg::kind_e  kind_i,
  input  wire logic [7:0]       effect_i,
  input  wire logic [15:0]      value_i,
  input  wire logic             arp_i,
  output trre_pkg::append_t     app_o
);

  logic [7:0]  lo;
  logic [8:0]  pat_op;
  logic [7:0]  op;
  logic [15:0] dat;
  logic        eff_en;

  assign lo     = value_i[7:0];
  assign pat_op = {1'b0, effect_i} + {1'b0, trre_pkg::PATTERN_BASE};

  always_comb begin
    op     = effect_i;
    dat    = value_i;
    eff_en = 1'b0;
    app_o  = '0;
    case (kind_i)
      trre_pkg::KIND_BYTE: begin
        app_o.count    = 2'd1;
        app_o.bytes[0] = lo;
      end
      trre_pkg::KIND_EFFECT: begin
        eff_en = (effect_i != 8'd0) && (effect_i < trre_pkg::OPCODE_LIMIT);
      end
      trre_pkg::KIND_PATTERN: begin
        op  = pat_op[7:0];
        dat = {8'd0, lo};
        eff_en = ((effect_i != 8'd0) || (lo != 8'd0) || arp_i) &&
                 (pat_op < {1'b0, trre_pkg::OPCODE_LIMIT});
      end
      trre_pkg::KIND_VOLUME: begin
        if ((effect_i != 8'd0) || (lo != 8'd0)) begin
          app_o.count    = 2'd3;
          app_o.bytes[0] = trre_pkg::VOLUME_OPCODE;
          app_o.bytes[1] = effect_i;
          app_o.bytes[2] = lo;
        end
      end
      default: begin
      end
    endcase

    if (eff_en) begin
      app_o.bytes[0] = op;
      if (trre_pkg::two_operands(op)) begin
        app_o.count    = 2'd3;
        app_o.bytes[1] = dat[15:8];
        app_o.bytes[2] = dat[7:0];
      end else begin
        app_o.count    = 2'd2;
        app_o.bytes[1] = dat[7:0];
      end
    end
  end

endmodule

`default_nettype wire

>>> design/trre_seq.sv
// Sequencer of the track row encoder: appends bytes with a running compare against
// the previous row, merges or emits rows, and drives the output register.
// Depends on trre_pkg; drives the ports of trre_row_mem.
`timescale 1ns / 1ps
`default_nettype none

module trre_seq #(
  parameter int unsigned RowPayloadMax = trre_pkg::ROW_PAYLOAD_MAX_DEF,
  parameter int unsigned RepeatMax     = trre_pkg::REPEAT_MAX_DEF,
  localparam int unsigned LenW  = $clog2(RowPayloadMax + 1),
  localparam int unsigned IdxW  = (RowPayloadMax > 1) ? $clog2(RowPayloadMax) : 1,
  localparam int unsigned AddrW = IdxW + 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire trre_pkg::kind_e   kind_i,
  input  wire trre_pkg::append_t app_i,
  output logic                   mem_we_o,
  output logic [AddrW-1:0]       mem_waddr_o,
  output logic [7:0]             mem_wdata_o,
  output logic                   mem_re_o,
  output logic [AddrW-1:0]       mem_raddr_o,
  input  wire logic [7:0]        mem_rdata_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [7:0]             out_byte_o,
  output logic                   last_of_run_o,
  output logic                   row_overflow_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPEND,
    ST_EMIT_HDR,
    ST_EMIT_DATA,
    ST_TERM
  } state_e;

  localparam logic [LenW-1:0]            LEN_MAX = LenW'(RowPayloadMax);
  localparam logic [trre_pkg::REP_W-1:0] REP_MAX = trre_pkg::REP_W'(RepeatMax);
  localparam logic [trre_pkg::REP_W-1:0] REP_ONE = trre_pkg::REP_W'(1);

  state_e                     state_q, state_d;
  logic                       bank_q, bank_d;
  logic [LenW-1:0]            cur_len_q, cur_len_d;
  logic [LenW-1:0]            prev_len_q, prev_len_d;
  logic [trre_pkg::REP_W-1:0] rep_q, rep_d;
  logic                       have_q, have_d;
  logic                       cur_ovf_q, cur_ovf_d;
  logic                       pend_ovf_q, pend_ovf_d;
  logic                       match_q, match_d;
  logic [2:0][7:0]            qb_q, qb_d;
  logic [1:0]                 qcnt_q, qcnt_d;
  logic [LenW-1:0]            emit_idx_q, emit_idx_d;
  logic                       track_q, track_d;
  logic                       out_valid_q, out_valid_d;
  logic [7:0]                 out_byte_q, out_byte_d;
  logic                       out_last_q, out_last_d;
  logic                       out_ovf_q, out_ovf_d;

  logic            out_free;
  logic [IdxW-1:0] rd_idx;
  logic [LenW-1:0] emit_nxt;
  logic [7:0]      hdr;

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit_nxt = emit_idx_q + LenW'(1);
  assign hdr      = {3'(rep_q - REP_ONE),
                     5'(32'(prev_len_q) + 32'd1) & trre_pkg::LENGTH_MASK};

  always_comb begin
    state_d     = state_q;
    bank_d      = bank_q;
    cur_len_d   = cur_len_q;
    prev_len_d  = prev_len_q;
    rep_d       = rep_q;
    have_d      = have_q;
    cur_ovf_d   = cur_ovf_q;
    pend_ovf_d  = pend_ovf_q;
    match_d     = match_q;
    qb_d        = qb_q;
    qcnt_d      = qcnt_q;
    emit_idx_d  = emit_idx_q;
    track_d     = track_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    rd_idx      = cur_len_q[IdxW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (kind_i)
            trre_pkg::KIND_BYTE, trre_pkg::KIND_EFFECT,
            trre_pkg::KIND_PATTERN, trre_pkg::KIND_VOLUME: begin
              if (app_i.count != 2'd0) begin
                // Fetch the previous row's byte at the slot the first byte lands in.
                qb_d     = app_i.bytes;
                qcnt_d   = app_i.count;
                mem_re_o = 1'b1;
                state_d  = ST_APPEND;
              end
            end
            trre_pkg::KIND_ROW_END: begin
              if (!have_q) begin
                bank_d     = !bank_q;
                prev_len_d = cur_len_q;
                rep_d      = REP_ONE;
                have_d     = 1'b1;
                pend_ovf_d = cur_ovf_q;
                cur_ovf_d  = 1'b0;
                cur_len_d  = '0;
                match_d    = 1'b1;
              end else if ((cur_len_q == prev_len_q) && (rep_q < REP_MAX) && match_q) begin
                rep_d      = rep_q + REP_ONE;
                pend_ovf_d = pend_ovf_q | cur_ovf_q;
                cur_ovf_d  = 1'b0;
                cur_len_d  = '0;
                match_d    = 1'b1;
              end else begin
                track_d = 1'b0;
                state_d = ST_EMIT_HDR;
              end
            end
            trre_pkg::KIND_TRACK_END: begin
              track_d = 1'b1;
              state_d = have_q ? ST_EMIT_HDR : ST_TERM;
            end
            trre_pkg::KIND_START: begin
              prev_len_d = '0;
              rep_d      = REP_ONE;
              cur_len_d  = '0;
              have_d     = 1'b0;
              cur_ovf_d  = 1'b0;
              pend_ovf_d = 1'b0;
              match_d    = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      ST_APPEND: begin
        if (cur_len_q < LEN_MAX) begin
          mem_we_o  = 1'b1;
          match_d   = match_q && (cur_len_q < prev_len_q) && (mem_rdata_i == qb_q[0]);
          cur_len_d = cur_len_q + LenW'(1);
        end else begin
          cur_ovf_d = 1'b1;
        end
        qb_d   = {8'd0, qb_q[2], qb_q[1]};
        qcnt_d = qcnt_q - 2'd1;
        if (qcnt_q > 2'd1) begin
          mem_re_o = 1'b1;
          rd_idx   = cur_len_d[IdxW-1:0];
        end else begin
          state_d = ST_IDLE;
        end
      end

      ST_EMIT_HDR, ST_EMIT_DATA: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_ovf_d   = pend_ovf_q;
          if (state_q == ST_EMIT_HDR) begin
            out_byte_d = hdr;
            out_last_d = (prev_len_q == '0) && !track_q;
            emit_idx_d = '0;
          end else begin
            out_byte_d = mem_rdata_i;
            out_last_d = (emit_nxt == prev_len_q) && !track_q;
            emit_idx_d = emit_nxt;
          end

          if (emit_idx_d < prev_len_q) begin
            mem_re_o = 1'b1;
            rd_idx   = emit_idx_d[IdxW-1:0];
            state_d  = ST_EMIT_DATA;
          end else if (track_q) begin
            state_d = ST_TERM;
          end else begin
            // The finished row becomes the pending one once the old one is out.
            bank_d     = !bank_q;
            prev_len_d = cur_len_q;
            rep_d      = REP_ONE;
            have_d     = 1'b1;
            pend_ovf_d = cur_ovf_q;
            cur_ovf_d  = 1'b0;
            cur_len_d  = '0;
            match_d    = 1'b1;
            state_d    = ST_IDLE;
          end
        end
      end

      ST_TERM: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = 8'd0;
          out_last_d  = 1'b1;
          out_ovf_d   = 1'b0;
          prev_len_d  = '0;
          rep_d       = REP_ONE;
          cur_len_d   = '0;
          have_d      = 1'b0;
          cur_ovf_d   = 1'b0;
          pend_ovf_d  = 1'b0;
          match_d     = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bank_q      <= 1'b0;
      cur_len_q   <= '0;
      prev_len_q  <= '0;
      rep_q       <= REP_ONE;
      have_q      <= 1'b0;
      cur_ovf_q   <= 1'b0;
      pend_ovf_q  <= 1'b0;
      match_q     <= 1'b1;
      qcnt_q      <= '0;
      emit_idx_q  <= '0;
      track_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bank_q      <= bank_d;
      cur_len_q   <= cur_len_d;
      prev_len_q  <= prev_len_d;
      rep_q       <= rep_d;
      have_q      <= have_d;
      cur_ovf_q   <= cur_ovf_d;
      pend_ovf_q  <= pend_ovf_d;
      match_q     <= match_d;
      qcnt_q      <= qcnt_d;
      emit_idx_q  <= emit_idx_d;
      track_q     <= track_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qb_q       <= qb_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign mem_waddr_o    = {bank_q, cur_len_q[IdxW-1:0]};
  assign mem_wdata_o    = qb_q[0];
  assign mem_raddr_o    = {!bank_q, rd_idx};
  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign last_of_run_o  = out_last_q;
  assign row_overflow_o = out_ovf_q;

  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_len_q <= LEN_MAX) && (prev_len_q <= LEN_MAX))
    else $error("row length beyond the payload limit");

  a_rep_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rep_q >= REP_ONE) && (rep_q <= REP_MAX))
    else $error("repeat count out of range");

  a_emit_idx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT_DATA) |-> (emit_idx_q < prev_len_q))
    else $error("emission index past the pending row");

  a_start_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (kind_i == trre_pkg::KIND_START))
      |=> (!have_q && (cur_len_q == '0) && (state_q == ST_IDLE)))
    else $error("start transaction did not clear the row state");

endmodule

`default_nettype wire

>>> design/track_row_rle_encoder.sv
// Track row encoder top level: APB register, command decoder, sequencer and row RAM.
// Depends on trre_pkg, trre_cmd_decode, trre_row_mem and trre_seq.
//
// Commands enter on the in_* channel (kind_i, effect_i, value_i); an input
// transaction completes when in_valid_i is high and in_stall_o is low. Encoded
// bytes leave on the out_* channel, one per transaction, with last_of_run_o on
// the final byte caused by a command and row_overflow_o on rows that lost bytes.
// A command that appends n bytes (0 to 3) is accepted in ST_IDLE, then each byte
// is appended in ST_APPEND with one RAM write while the previous row's byte at
// the same slot, read in the cycle before, feeds a running compare. Row ends that
// merge or just store the row are handled within ST_IDLE. A row end that emits
// loads its header into the output register from ST_EMIT_HDR, then one payload
// byte per cycle from the registered RAM read while the receiver does not stall;
// end of track adds the zero terminator from ST_TERM. While the receiver stalls,
// the output register holds its byte and emission waits. Reset clears the row
// state and the arpeggio_memory register; the row RAM needs no clearing pass, as
// bytes read at or above the stored lengths go unused. Configure only while idle.
`timescale 1ns / 1ps
`default_nettype none

module track_row_rle_encoder #(
  parameter int unsigned RowPayloadMax = trre_pkg::ROW_PAYLOAD_MAX_DEF,
  parameter int unsigned RepeatMax     = trre_pkg::REPEAT_MAX_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [trre_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [2:0]                      kind_i,
  input  wire logic [7:0]                      effect_i,
  input  wire logic [15:0]                     value_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [7:0]                      out_byte_o,
  output logic                                 last_of_run_o,
  output logic                                 row_overflow_o
);

  localparam int unsigned IdxW  = (RowPayloadMax > 1) ? $clog2(RowPayloadMax) : 1;
  localparam int unsigned AddrW = IdxW + 1;

  logic              arp_q;
  logic              reg_sel;
  trre_pkg::kind_e   kind;
  trre_pkg::append_t app;
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_re;
  logic [AddrW-1:0]  mem_raddr;
  logic [7:0]        mem_rdata;

  // Register 0 occupies byte addresses 0 to 3.
  assign reg_sel = (paddr[trre_pkg::APB_ADDR_W-1:2] == '0);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {31'd0, arp_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arp_q <= 1'b0;
    end else if (psel && penable && pwrite && reg_sel) begin
      arp_q <= pwdata[0];
    end
  end

  assign kind = trre_pkg::kind_e'(kind_i);

  trre_cmd_decode u_decode (
    .kind_i   (kind),
    .effect_i (effect_i),
    .value_i  (value_i),
    .arp_i    (arp_q),
    .app_o    (app)
  );

  trre_row_mem #(
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  trre_seq #(
    .RowPayloadMax (RowPayloadMax),
    .RepeatMax     (RepeatMax)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind),
    .app_i          (app),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .last_of_run_o  (last_of_run_o),
    .row_overflow_o (row_overflow_o)
  );

endmodule

`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for track_row_rle_encoder: random and directed command streams,
// a scoreboard class that predicts the encoded byte stream, and APB register writes.
// Depends on trre_pkg and the track_row_rle_encoder RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int ROW_MAX = trre_pkg::ROW_PAYLOAD_MAX_DEF;
  localparam int REP_MAX = trre_pkg::REPEAT_MAX_DEF;
  localparam logic [2:0] KIND_UNUSED = 3'd7;
  localparam logic [trre_pkg::APB_ADDR_W-1:0] ADDR_ARPEGGIO = '0;

  // Opcodes whose operand is a big-endian word, one bit per opcode.
  localparam logic [63:0] WIDE_OPS = (64'd1 << 30) | (64'd1 << 54) | (64'd1 << 56) |
                                     (64'd1 << 57) | (64'd1 << 61);
  localparam logic [7:0] OP_NONE = 8'd0;
  localparam logic [7:0] OP_FIRST = 8'd1;
  localparam logic [7:0] OP_NO_ARG = 8'd28;
  localparam logic [7:0] OP_WIDE_LAST = 8'd61;
  localparam logic [7:0] OP_TOP = 8'hff;

  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  eff;
    logic [15:0] val;
  } cmd_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       ovf;
  } track_byte_t;

  class track_scoreboard;
    bit          arp_mem;
    logic [7:0]  prev_row [ROW_MAX];
    logic [7:0]  cur_row [ROW_MAX];
    logic [4:0]  prev_len;
    logic [4:0]  cur_len;
    logic [3:0]  prev_rep;
    bit          have_prev;
    bit          cur_ovf;
    bit          pend_ovf;
    track_byte_t expected [$];
    track_byte_t fresh [$];
    int          errors;

    function new();
      arp_mem = 0;
      errors = 0;
      clear_rows();
    endfunction

    function void clear_rows();
      foreach (prev_row[i]) begin
        prev_row[i] = 8'h00;
        cur_row[i] = 8'h00;
      end
      prev_len = 5'd0;
      prev_rep = 4'd1;
      cur_len = 5'd0;
      have_prev = 0;
      cur_ovf = 0;
      pend_ovf = 0;
    endfunction

    function void append(logic [7:0] b);
      if (cur_len < ROW_MAX) begin
        cur_row[cur_len] = b;
        cur_len++;
      end else begin
        cur_ovf = 1;
      end
    endfunction

    function void add_effect(int op, logic [15:0] arg);
      if (op == 0 || op >= trre_pkg::OPCODE_LIMIT) return;
      append(op[7:0]);
      if (WIDE_OPS[op]) append(arg[15:8]);
      append(arg[7:0]);
    endfunction

    function void emit(logic [7:0] b, bit ovf);
      track_byte_t t;
      t.data = b;
      t.last = 1'b0;
      t.ovf = ovf;
      fresh.push_back(t);
    endfunction

    function void flush_pending();
      logic [3:0] rep_m1;
      logic [4:0] len_p1;
      rep_m1 = prev_rep - 4'd1;
      len_p1 = prev_len + 5'd1;
      emit({rep_m1[2:0], len_p1}, pend_ovf);
      for (int i = 0; i < prev_len; i++) emit(prev_row[i], pend_ovf);
    endfunction

    function void promote();
      prev_row = cur_row;
      prev_len = cur_len;
      prev_rep = 4'd1;
      have_prev = 1;
      pend_ovf = cur_ovf;
      cur_ovf = 0;
      cur_len = 5'd0;
    endfunction

    function bit rows_match();
      if (cur_len != prev_len || prev_rep >= REP_MAX) return 0;
      for (int i = 0; i < cur_len; i++)
        if (cur_row[i] != prev_row[i]) return 0;
      return 1;
    endfunction

    // Works out the bytes that one accepted command produces and queues them.
    function void note_command(logic [2:0] kind, logic [7:0] eff, logic [15:0] val);
      fresh.delete();
      case (kind)
        trre_pkg::KIND_BYTE: append(val[7:0]);
        trre_pkg::KIND_EFFECT: add_effect(int'(eff), val);
        trre_pkg::KIND_PATTERN: begin
          if (eff != 0 || val[7:0] != 0 || arp_mem)
            add_effect(int'(trre_pkg::PATTERN_BASE) + int'(eff), {8'h00, val[7:0]});
        end
        trre_pkg::KIND_VOLUME: begin
          if (eff != 0 || val[7:0] != 0) begin
            append(trre_pkg::VOLUME_OPCODE);
            append(eff);
            append(val[7:0]);
          end
        end
        trre_pkg::KIND_ROW_END: begin
          if (!have_prev) begin
            promote();
          end else if (rows_match()) begin
            prev_rep++;
            pend_ovf |= cur_ovf;
            cur_ovf = 0;
            cur_len = 5'd0;
          end else begin
            flush_pending();
            promote();
          end
        end
        trre_pkg::KIND_TRACK_END: begin
          if (have_prev) flush_pending();
          emit(8'h00, 0);
          clear_rows();
        end
        trre_pkg::KIND_START: clear_rows();
        default: ;
      endcase
      if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
      foreach (fresh[i]) expected.push_back(fresh[i]);
    endfunction

    function void check_byte(logic [7:0] b, logic last, logic ovf);
      track_byte_t want;
      if (expected.size() == 0) begin
        $error("unexpected output byte %02h", b);
        errors++;
        return;
      end
      want = expected.pop_front();
      if (b !== want.data) begin
        $error("out_byte: expected %02h, got %02h", want.data, b);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %0b, got %0b", want.last, last);
        errors++;
      end
      if (ovf !== want.ovf) begin
        $error("row_overflow: expected %0b, got %0b", want.ovf, ovf);
        errors++;
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [trre_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [31:0]                     pwdata = '0;
  logic [31:0]                     prdata;
  logic                            pready;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [2:0]                      kind = 3'd0;
  logic [7:0]                      effect = 8'd0;
  logic [15:0]                     value = 16'd0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [7:0]                      out_byte;
  logic                            out_last;
  logic                            out_ovf;

  track_scoreboard sb = new();
  int  sent = 0;
  int  idle_cycles = 0;
  int  stall_left = 0;
  bit  quiet = 0;
  bit  calm = 0;
  bit  out_calm = 0;

  track_row_rle_encoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .kind_i         (kind),
    .effect_i       (effect),
    .value_i        (value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_byte_o     (out_byte),
    .last_of_run_o  (out_last),
    .row_overflow_o (out_ovf)
  );

  always #5 clk_i = ~clk_i;

  // Receiver back-pressure: stall bursts of random length, with calm stretches.
  always @(posedge clk_i) begin
    if ($urandom_range(0, 63) == 0) out_calm <= ~out_calm;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!quiet && !out_calm && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid === 1'b1 && out_stall == 1'b0)
      sb.check_byte(out_byte, out_last, out_ovf);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_cmd(input logic [2:0] k, input logic [7:0] e, input logic [15:0] v);
    int gap;
    if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    kind <= k;
    effect <= e;
    value <= v;
    do @(posedge clk_i); while (in_stall !== 1'b0);
    sb.note_command(k, e, v);
    sent++;
  endtask

  // Holds the sender off until every predicted byte has come out.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [trre_pkg::APB_ADDR_W-1:0] addr, input bit data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {31'd0, data};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_ARPEGGIO) sb.arp_mem = data;
  endtask

  function automatic logic [7:0] wide_opcode();
    logic [7:0] op;
    do op = 8'($urandom_range(1, OP_WIDE_LAST)); while (!WIDE_OPS[op]);
    return op;
  endfunction

  function automatic cmd_t random_payload();
    cmd_t c;
    int   pick;
    c.val = 16'($urandom);
    c.eff = 8'($urandom);
    pick = $urandom_range(0, 9);
    case ($urandom_range(0, 3))
      0: c.kind = trre_pkg::KIND_BYTE;
      1: begin
        c.kind = trre_pkg::KIND_EFFECT;
        if (pick == 0) c.eff = OP_NONE;
        else if (pick == 1) c.eff = 8'($urandom_range(trre_pkg::OPCODE_LIMIT, OP_TOP));
        else if (pick <= 3) c.eff = wide_opcode();
        else c.eff = 8'($urandom_range(OP_FIRST, trre_pkg::OPCODE_LIMIT - 1));
      end
      2: begin
        c.kind = trre_pkg::KIND_PATTERN;
        // Zero numbers exercise the skip rule; large ones run past the opcode table.
        if (pick <= 2) c.eff = 8'd0;
        else if (pick == 3) c.eff = wide_opcode() - trre_pkg::PATTERN_BASE;
        else if (pick == 4) c.eff = 8'($urandom);
        else c.eff = 8'($urandom_range(0, trre_pkg::OPCODE_LIMIT - trre_pkg::PATTERN_BASE));
        if ($urandom_range(0, 2) == 0) c.val[7:0] = 8'h00;
      end
      default: begin
        c.kind = trre_pkg::KIND_VOLUME;
        if ($urandom_range(0, 3) == 0) c.eff = 8'd0;
        if ($urandom_range(0, 3) == 0) c.val[7:0] = 8'h00;
      end
    endcase
    return c;
  endfunction

  task automatic run_directed();
    send_cmd(trre_pkg::KIND_START, 8'($urandom), 16'($urandom));
    send_cmd(trre_pkg::KIND_BYTE, 8'($urandom), 16'hffff);
    send_cmd(trre_pkg::KIND_BYTE, 8'($urandom), 16'h0000);
    send_cmd(trre_pkg::KIND_EFFECT, OP_NONE, 16'($urandom));
    send_cmd(trre_pkg::KIND_EFFECT, trre_pkg::OPCODE_LIMIT, 16'($urandom));
    send_cmd(trre_pkg::KIND_EFFECT, OP_TOP, 16'($urandom));
    send_cmd(trre_pkg::KIND_EFFECT, trre_pkg::VOLUME_OPCODE, 16'ha55a);
    send_cmd(trre_pkg::KIND_EFFECT, OP_WIDE_LAST, 16'hffff);
    send_cmd(trre_pkg::KIND_EFFECT, OP_NO_ARG, 16'h1234);
    send_cmd(trre_pkg::KIND_EFFECT, OP_FIRST, 16'hff00);
    send_cmd(trre_pkg::KIND_PATTERN, 8'd0, 16'hab00);
    send_cmd(trre_pkg::KIND_PATTERN, 8'd5, 16'h03c7);
    send_cmd(trre_pkg::KIND_PATTERN, trre_pkg::OPCODE_LIMIT - trre_pkg::PATTERN_BASE,
             16'h0011);
    send_cmd(trre_pkg::KIND_PATTERN, trre_pkg::VOLUME_OPCODE - trre_pkg::PATTERN_BASE,
             16'h5a96);
    send_cmd(trre_pkg::KIND_VOLUME, 8'd0, 16'hcd00);
    send_cmd(trre_pkg::KIND_VOLUME, 8'hff, 16'hffff);
    // First row end only stores the row; the next two emit it and then merge empties.
    send_cmd(trre_pkg::KIND_ROW_END, 8'($urandom), 16'($urandom));
    send_cmd(KIND_UNUSED, 8'hff, 16'hffff);
    send_cmd(trre_pkg::KIND_ROW_END, 8'($urandom), 16'($urandom));
    send_cmd(trre_pkg::KIND_ROW_END, 8'($urandom), 16'($urandom));
    send_cmd(trre_pkg::KIND_BYTE, 8'($urandom), 16'h0080);
    send_cmd(trre_pkg::KIND_ROW_END, 8'($urandom), 16'($urandom));
    send_cmd(trre_pkg::KIND_BYTE, 8'($urandom), 16'h0081);
    send_cmd(trre_pkg::KIND_TRACK_END, 8'($urandom), 16'($urandom));
    send_cmd(trre_pkg::KIND_TRACK_END, 8'($urandom), 16'($urandom));
  endtask

  // Tracks of rows that mostly repeat, so merging, the repeat limit and full rows
  // are reached; stray commands and open tracks are mixed in.
  task automatic play_tracks(input int budget, input bit wind_down);
    cmd_t row [$];
    cmd_t c;
    int   first;
    int   rows;
    int   reps;
    int   n;
    bit   long_row;
    first = sent;
    while (sent - first < budget) begin
      if (wind_down && sent - first >= budget - 30) quiet = 1;
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0)
        send_cmd(trre_pkg::KIND_START, 8'($urandom), 16'($urandom));
      rows = $urandom_range(1, 6);
      for (int r = 0; r < rows && sent - first < budget; r++) begin
        row.delete();
        long_row = ($urandom_range(0, 5) == 0);
        n = long_row ? $urandom_range(10, 13) : $urandom_range(0, 4);
        for (int i = 0; i < n; i++) begin
          if (long_row) begin
            c.kind = trre_pkg::KIND_VOLUME;
            c.eff = 8'($urandom_range(1, 255));
            c.val = 16'($urandom);
          end else begin
            c = random_payload();
          end
          row.push_back(c);
        end
        if (long_row || $urandom_range(0, 3) != 0) reps = $urandom_range(1, 3);
        else reps = $urandom_range(REP_MAX - 1, REP_MAX + 2);
        for (int k = 0; k < reps; k++) begin
          foreach (row[i]) send_cmd(row[i].kind, row[i].eff, row[i].val);
          if ($urandom_range(0, 7) == 0) begin
            c = random_payload();
            send_cmd(c.kind, c.eff, c.val);
          end
          if ($urandom_range(0, 15) == 0)
            send_cmd(KIND_UNUSED, 8'($urandom), 16'($urandom));
          send_cmd(trre_pkg::KIND_ROW_END, 8'($urandom), 16'($urandom));
        end
      end
      case ($urandom_range(0, 7))
        0: ;
        1: begin
          c = random_payload();
          send_cmd(c.kind, c.eff, c.val);
          send_cmd(trre_pkg::KIND_TRACK_END, 8'($urandom), 16'($urandom));
        end
        default: send_cmd(trre_pkg::KIND_TRACK_END, 8'($urandom), 16'($urandom));
      endcase
      if (!quiet && $urandom_range(0, 7) == 0) drain();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    drain();
    apb_write(ADDR_ARPEGGIO, 1'b1);
    play_tracks(40, 0);
    drain();
    apb_write(ADDR_ARPEGGIO, 1'b0);
    play_tracks(40, 0);
    drain();
    apb_write(ADDR_ARPEGGIO, 1'b1);
    play_tracks(35, 1);
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
